// ----- hdl/ctp_pkg.sv -----
`default_nettype none

package ctp_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned OwnerW  = 8;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned ActionW = 4;
  localparam int unsigned KindW   = 3;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned CountW  = 7;

  typedef enum logic [ModeW-1:0] {
    MODE_SCHED   = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KIND_SCHED    = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_EXPIRED  = 3'd2,
    KIND_QUIET    = 3'd3,
    KIND_RELEASED = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // one slot of the pool as held in memory
  typedef struct packed {
    logic [TicksW-1:0]  ticks;
    logic [OwnerW-1:0]  owner;
    logic [ActionW-1:0] action;
    logic               armed;
  } entry_t;

  // write command from sequencer to slot store
  typedef struct packed {
    logic   set;
    logic   clr;
    entry_t data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ----- hdl/ctp_mem.sv -----
`default_nettype none

module ctp_mem #(
  parameter int unsigned TIMER_SLOTS = 64,
  localparam int unsigned IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [IdxW-1:0]   rd_addr_i,
  output ctp_pkg::entry_t        rd_data_o,
  input  wire logic [IdxW-1:0]   wr_addr_i,
  input  ctp_pkg::mem_wr_t       wr_i
);

  ctp_pkg::entry_t mem_q [TIMER_SLOTS];
  ctp_pkg::entry_t rd_q;
  logic [TIMER_SLOTS-1:0] valid_q;
  logic                   rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.set) begin
      mem_q[wr_addr_i] <= wr_i.data;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // a slot without its valid bit reads as the all-zero reset entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.set) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (wr_i.clr) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
      rvalid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rvalid_q ? rd_q : '0;

endmodule

`default_nettype wire

// ----- hdl/ctp_ctrl.sv -----
`default_nettype none

module ctp_ctrl #(
  parameter int unsigned TIMER_SLOTS = 64,
  localparam int unsigned IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1,
  localparam int unsigned CntW = $clog2(TIMER_SLOTS + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ctp_pkg::ModeW-1:0]     mode_i,
  input  wire logic [ctp_pkg::OwnerW-1:0]    owner_i,
  input  wire logic [ctp_pkg::TicksW-1:0]    duration_i,
  input  wire logic [ctp_pkg::ActionW-1:0]   action_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ctp_pkg::KindW-1:0]          kind_o,
  output logic [ctp_pkg::SlotW-1:0]          slot_o,
  output logic [ctp_pkg::OwnerW-1:0]         expired_owner_o,
  output logic [ctp_pkg::ActionW-1:0]        expired_action_o,
  output logic [ctp_pkg::CountW-1:0]         cleared_count_o,
  output logic                               last_o,
  output logic [IdxW-1:0]                    rd_addr_o,
  input  ctp_pkg::entry_t                    rd_data_i,
  output logic [IdxW-1:0]                    wr_addr_o,
  output ctp_pkg::mem_wr_t                   wr_o
);

  ctp_pkg::state_e state_q, state_d;
  ctp_pkg::mode_e  mode_q, mode_d;
  logic [ctp_pkg::OwnerW-1:0]  owner_q, owner_d;
  logic [ctp_pkg::TicksW-1:0]  dur_q, dur_d;
  logic [ctp_pkg::ActionW-1:0] act_q, act_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [CntW-1:0]             cnt_q, cnt_d;

  // held expiry: its last flag is known only once a later expiry or the end is seen
  logic                        pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]             pend_slot_q, pend_slot_d;
  logic [ctp_pkg::OwnerW-1:0]  pend_owner_q, pend_owner_d;
  logic [ctp_pkg::ActionW-1:0] pend_action_q, pend_action_d;

  logic                        out_valid_q, out_valid_d;
  ctp_pkg::kind_e              out_kind_q, ld_kind;
  logic [ctp_pkg::SlotW-1:0]   out_slot_q, ld_slot;
  logic [ctp_pkg::OwnerW-1:0]  out_owner_q, ld_owner;
  logic [ctp_pkg::ActionW-1:0] out_action_q, ld_action;
  logic [ctp_pkg::CountW-1:0]  out_cnt_q, ld_cnt;
  logic                        out_last_q, ld_last;
  logic                        out_load;

  logic                        out_free;
  logic                        last_slot;
  logic                        advance;
  logic                        expire;
  logic [ctp_pkg::TicksW-1:0]  ticks_dec;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_slot = (idx_q == IdxW'(TIMER_SLOTS - 1));
  assign ticks_dec = (rd_data_i.ticks != '0) ? (rd_data_i.ticks - 1'b1) : rd_data_i.ticks;
  assign expire    = (ticks_dec == '0) && rd_data_i.armed;
  assign wr_addr_o = idx_q;

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    owner_d       = owner_q;
    dur_d         = dur_q;
    act_d         = act_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    pend_valid_d  = pend_valid_q;
    pend_slot_d   = pend_slot_q;
    pend_owner_d  = pend_owner_q;
    pend_action_d = pend_action_q;
    in_ready_o    = 1'b0;
    rd_addr_o     = idx_q;
    wr_o          = '0;
    advance       = 1'b0;
    out_load      = 1'b0;
    ld_kind       = ctp_pkg::KIND_SCHED;
    ld_slot       = '0;
    ld_owner      = '0;
    ld_action     = '0;
    ld_cnt        = '0;
    ld_last       = 1'b1;

    unique case (state_q)
      ctp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr_o  = '0;
        if (in_valid_i && (ctp_pkg::mode_e'(mode_i) != ctp_pkg::MODE_NONE)) begin
          mode_d       = ctp_pkg::mode_e'(mode_i);
          owner_d      = owner_i;
          dur_d        = duration_i;
          act_d        = action_i;
          idx_d        = '0;
          cnt_d        = '0;
          pend_valid_d = 1'b0;
          state_d      = ctp_pkg::ST_SCAN;
        end
      end

      ctp_pkg::ST_SCAN: begin
        advance = 1'b1;
        unique case (mode_q)
          ctp_pkg::MODE_SCHED: begin
            // zero count means free, armed or not
            if (rd_data_i.ticks == '0) begin
              advance = 1'b0;
              if (out_free) begin
                wr_o.set         = 1'b1;
                wr_o.data.ticks  = dur_q;
                wr_o.data.owner  = owner_q;
                wr_o.data.action = act_q;
                wr_o.data.armed  = 1'b1;
                out_load         = 1'b1;
                ld_kind          = ctp_pkg::KIND_SCHED;
                ld_slot          = ctp_pkg::SlotW'(idx_q);
                state_d          = ctp_pkg::ST_IDLE;
              end
            end
          end
          ctp_pkg::MODE_TICK: begin
            if (expire && pend_valid_q && !out_free) begin
              advance = 1'b0;
            end else if (expire) begin
              wr_o.clr = 1'b1;
              if (pend_valid_q) begin
                out_load  = 1'b1;
                ld_kind   = ctp_pkg::KIND_EXPIRED;
                ld_slot   = ctp_pkg::SlotW'(pend_slot_q);
                ld_owner  = pend_owner_q;
                ld_action = pend_action_q;
                ld_last   = 1'b0;
              end
              pend_valid_d  = 1'b1;
              pend_slot_d   = idx_q;
              pend_owner_d  = rd_data_i.owner;
              pend_action_d = rd_data_i.action;
            end else if (rd_data_i.ticks != '0) begin
              wr_o.set        = 1'b1;
              wr_o.data       = rd_data_i;
              wr_o.data.ticks = ticks_dec;
            end
          end
          ctp_pkg::MODE_RELEASE: begin
            if (rd_data_i.owner == owner_q) begin
              wr_o.clr = 1'b1;
              cnt_d    = cnt_q + CntW'(rd_data_i.armed);
            end
          end
          default: begin
            advance = 1'b0;
            state_d = ctp_pkg::ST_IDLE;
          end
        endcase
        if (advance) begin
          if (last_slot) begin
            state_d = ctp_pkg::ST_FINISH;
          end else begin
            idx_d     = idx_q + 1'b1;
            rd_addr_o = idx_q + 1'b1;
          end
        end
      end

      ctp_pkg::ST_FINISH: begin
        rd_addr_o = '0;
        if (out_free) begin
          out_load = 1'b1;
          unique case (mode_q)
            ctp_pkg::MODE_SCHED: ld_kind = ctp_pkg::KIND_FULL;
            ctp_pkg::MODE_TICK: begin
              if (pend_valid_q) begin
                ld_kind   = ctp_pkg::KIND_EXPIRED;
                ld_slot   = ctp_pkg::SlotW'(pend_slot_q);
                ld_owner  = pend_owner_q;
                ld_action = pend_action_q;
              end else begin
                ld_kind = ctp_pkg::KIND_QUIET;
              end
            end
            ctp_pkg::MODE_RELEASE: begin
              ld_kind = ctp_pkg::KIND_RELEASED;
              ld_cnt  = ctp_pkg::CountW'(cnt_q);
            end
            default: out_load = 1'b0;
          endcase
          pend_valid_d = 1'b0;
          state_d      = ctp_pkg::ST_IDLE;
        end
      end

      default: state_d = ctp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ctp_pkg::ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    owner_q       <= owner_d;
    dur_q         <= dur_d;
    act_q         <= act_d;
    idx_q         <= idx_d;
    cnt_q         <= cnt_d;
    pend_slot_q   <= pend_slot_d;
    pend_owner_q  <= pend_owner_d;
    pend_action_q <= pend_action_d;
    if (out_load) begin
      out_kind_q   <= ld_kind;
      out_slot_q   <= ld_slot;
      out_owner_q  <= ld_owner;
      out_action_q <= ld_action;
      out_cnt_q    <= ld_cnt;
      out_last_q   <= ld_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_kind_q;
  assign slot_o           = out_slot_q;
  assign expired_owner_o  = out_owner_q;
  assign expired_action_o = out_action_q;
  assign cleared_count_o  = out_cnt_q;
  assign last_o           = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/countdown_timer_pool.sv -----
// Each beat walks the slot store at most once, one slot per cycle through a single read port
// while output back-pressure does not stall the scan: tick and release visit every slot, schedule
// stops at the first free slot or walks all slots when full. Mode 3 is taken with no result.
// Reset clears the per-slot valid bits, so every slot reads as zero at once.
`default_nettype none

module countdown_timer_pool #(
  parameter int unsigned TIMER_SLOTS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ctp_pkg::ModeW-1:0]     mode_i,
  input  wire logic [ctp_pkg::OwnerW-1:0]    owner_i,
  input  wire logic [ctp_pkg::TicksW-1:0]    duration_i,
  input  wire logic [ctp_pkg::ActionW-1:0]   action_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ctp_pkg::KindW-1:0]          kind_o,
  output logic [ctp_pkg::SlotW-1:0]          slot_o,
  output logic [ctp_pkg::OwnerW-1:0]         expired_owner_o,
  output logic [ctp_pkg::ActionW-1:0]        expired_action_o,
  output logic [ctp_pkg::CountW-1:0]         cleared_count_o,
  output logic                               last_o
);

  localparam int unsigned IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  wr_addr;
  ctp_pkg::entry_t  rd_data;
  ctp_pkg::mem_wr_t wr;

  ctp_ctrl #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .owner_i          (owner_i),
    .duration_i       (duration_i),
    .action_i         (action_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .slot_o           (slot_o),
    .expired_owner_o  (expired_owner_o),
    .expired_action_o (expired_action_o),
    .cleared_count_o  (cleared_count_o),
    .last_o           (last_o),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .wr_addr_o        (wr_addr),
    .wr_o             (wr)
  );

  ctp_mem #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_addr_i (wr_addr),
    .wr_i      (wr)
  );

endmodule

`default_nettype wire

// ----- hdl/ctp_chk.sv -----
`default_nettype none

module ctp_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic [ctp_pkg::ModeW-1:0]     mode_i,
  input wire logic [ctp_pkg::OwnerW-1:0]    owner_i,
  input wire logic [ctp_pkg::TicksW-1:0]    duration_i,
  input wire logic [ctp_pkg::ActionW-1:0]   action_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [ctp_pkg::KindW-1:0]     kind_o,
  input wire logic [ctp_pkg::SlotW-1:0]     slot_o,
  input wire logic [ctp_pkg::OwnerW-1:0]    expired_owner_o,
  input wire logic [ctp_pkg::ActionW-1:0]   expired_action_o,
  input wire logic [ctp_pkg::CountW-1:0]    cleared_count_o,
  input wire logic                          last_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(slot_o)
      && $stable(last_o) && $stable(cleared_count_o))
    else $error("result beat changed while stalled");

  // only an expiry may be followed by further results of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != ctp_pkg::KIND_EXPIRED) |-> last_o)
    else $error("non-expiry result without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != ctp_pkg::KIND_EXPIRED)
      |-> (expired_owner_o == '0) && (expired_action_o == '0))
    else $error("expiry fields set on other result kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != ctp_pkg::KIND_RELEASED) |-> (cleared_count_o == '0))
    else $error("cleared count set outside release");

  // a real operation occupies the scanner for at least one slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i != ctp_pkg::MODE_NONE) |=> !in_ready_o)
    else $error("beat accepted during scan");

endmodule

bind countdown_timer_pool ctp_chk u_ctp_chk (.*);

`default_nettype wire
